// ===== rtl/per_client_bounded_queue_manager_defines.svh =====
// ----------------------------------------------------------------------------
// per-client bounded queue manager: assertion macros
// same-cycle and next-cycle implications, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_BOUNDED_QUEUE_MANAGER_DEFINES_SVH
`define PER_CLIENT_BOUNDED_QUEUE_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BCQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcq assertion failed");
`define BCQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcq assertion failed");
`else
`define BCQ_ASSERT_IMP(lbl, ante, cons)
`define BCQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/bcq_pkg.sv =====
// ----------------------------------------------------------------------------
// bcq_pkg
// types, codes and helpers shared by the per-client bounded queue manager
// ----------------------------------------------------------------------------
package bcq_pkg;

    localparam int CMD_W      = 3;
    localparam int CLIENT_W   = 4;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 3;
    localparam int LIMIT_W    = 5;
    localparam int CLIENT_EXT_W = 9;

    localparam int MAX_RESULTS     = 16;
    localparam int NUM_CLIENTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ENQ      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ_DROP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SIZE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PURGE    = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DRAINED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CLIENT_W-1:0] client_index;
        logic [DATA_W-1:0]   message_handle;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
        logic [COUNT_W-1:0]  queue_count;
        logic                last_result;
    } rsp_item_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic rsp_item_t make_rsp(
        input logic [STATUS_W-1:0] status,
        input logic [DATA_W-1:0]   data,
        input logic [COUNT_W-1:0]  count,
        input logic                last
    );
        rsp_item_t r;
        r.status      = status;
        r.data_out    = data;
        r.queue_count = count;
        r.last_result = last;
        return r;
    endfunction

endpackage

// ===== rtl/bcq_ctx_mem.sv =====
// ----------------------------------------------------------------------------
// bcq_ctx_mem
// per-client head pointer and entry count, one synchronous read port with
// registered output; entries never written read as an empty queue
// ----------------------------------------------------------------------------
module bcq_ctx_mem #(
    parameter int NUM_CLIENTS = bcq_pkg::NUM_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF,
    localparam int CIDX_W = bcq_pkg::idx_w(NUM_CLIENTS),
    localparam int PTR_W  = bcq_pkg::idx_w(QUEUE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [CIDX_W-1:0]           rd_addr,
    output logic [PTR_W-1:0]            rd_head,
    output logic [bcq_pkg::COUNT_W-1:0] rd_count,
    input  logic                        wr_en,
    input  logic [CIDX_W-1:0]           wr_addr,
    input  logic [PTR_W-1:0]            wr_head,
    input  logic [bcq_pkg::COUNT_W-1:0] wr_count
);
    import bcq_pkg::*;

    localparam int ENTRY_W = PTR_W + COUNT_W;

    logic [ENTRY_W-1:0]     ctx_mem_reg [NUM_CLIENTS];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [NUM_CLIENTS-1:0] valid_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctx_mem_reg[wr_addr] <= {wr_head, wr_count};
        end
        if (rd_en)
        begin
            rd_data_reg <= ctx_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_head  = rd_valid_reg ? rd_data_reg[ENTRY_W-1:COUNT_W] : '0;
    assign rd_count = rd_valid_reg ? rd_data_reg[COUNT_W-1:0] : '0;

endmodule

// ===== rtl/bcq_msg_mem.sv =====
// ----------------------------------------------------------------------------
// bcq_msg_mem
// message handle storage, one slot row per client, one write and one
// registered read per cycle; read data holds until the next read
// ----------------------------------------------------------------------------
module bcq_msg_mem #(
    parameter int NUM_CLIENTS = bcq_pkg::NUM_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF,
    localparam int ADDR_W = bcq_pkg::idx_w(NUM_CLIENTS) + bcq_pkg::idx_w(QUEUE_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bcq_pkg::DATA_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bcq_pkg::DATA_W-1:0] wr_data
);
    import bcq_pkg::*;

    localparam int WORDS = NUM_CLIENTS << idx_w(QUEUE_DEPTH);

    logic [DATA_W-1:0] msg_mem_reg [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            msg_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= msg_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bcq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcq_ctrl
// command sequencer: context lookup, read-modify-write of the queue state,
// eviction read, drain walk and the registered result stage
// ----------------------------------------------------------------------------
`include "per_client_bounded_queue_manager_defines.svh"

module bcq_ctrl #(
    parameter int NUM_CLIENTS = bcq_pkg::NUM_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF,
    localparam int CIDX_W = bcq_pkg::idx_w(NUM_CLIENTS),
    localparam int PTR_W  = bcq_pkg::idx_w(QUEUE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bcq_pkg::req_item_t            req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bcq_pkg::rsp_item_t            rsp_data,
    input  logic                          cfg_we,
    input  logic [bcq_pkg::LIMIT_W-1:0]   cfg_wdata,
    output logic                          ctx_rd_en,
    output logic [CIDX_W-1:0]             ctx_rd_addr,
    input  logic [PTR_W-1:0]              ctx_rd_head,
    input  logic [bcq_pkg::COUNT_W-1:0]   ctx_rd_count,
    output logic                          ctx_wr_en,
    output logic [CIDX_W-1:0]             ctx_wr_addr,
    output logic [PTR_W-1:0]              ctx_wr_head,
    output logic [bcq_pkg::COUNT_W-1:0]   ctx_wr_count,
    output logic                          msg_rd_en,
    output logic [CIDX_W+PTR_W-1:0]       msg_rd_addr,
    input  logic [bcq_pkg::DATA_W-1:0]    msg_rd_data,
    output logic                          msg_wr_en,
    output logic [CIDX_W+PTR_W-1:0]       msg_wr_addr,
    output logic [bcq_pkg::DATA_W-1:0]    msg_wr_data
);
    import bcq_pkg::*;

    localparam int SUM_W     = PTR_W + 1;
    localparam int LIMIT_CAP = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_DROP   = 2'd2;
    localparam logic [1:0] S_DRAIN  = 2'd3;

    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0]   a,
        input logic [COUNT_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic [1:0]          state_reg, state_next;
    req_item_t           req_reg;
    logic                in_range_reg;
    logic [CIDX_W-1:0]   client_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [PTR_W-1:0]    drop_slot_reg, drop_slot_next;
    logic [PTR_W-1:0]    drop_head_reg, drop_head_next;
    logic [COUNT_W-1:0]  drop_cnt_reg, drop_cnt_next;

    logic [PTR_W-1:0]    drain_head_reg, drain_head_next;
    logic [COUNT_W-1:0]  drain_cnt_reg, drain_cnt_next;
    logic [COUNT_W-1:0]  drain_idx_reg, drain_idx_next;
    logic                dv_reg, dv_next;

    logic                out_valid_reg;
    rsp_item_t           out_data_reg;

    logic [CLIENT_EXT_W-1:0] client_ext;
    logic                    in_range_now;
    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    rsp_item_t               out_item;
    logic [LIMIT_W-1:0]      lim_eff;
    logic                    full;
    logic [PTR_W-1:0]        tail_slot;
    logic [COUNT_W-1:0]      cnt_inc;
    logic                    drain_issue;

    assign client_ext   = CLIENT_EXT_W'(req_data.client_index);
    assign in_range_now = client_ext < CLIENT_EXT_W'(NUM_CLIENTS);
    assign req_stall    = state_reg != S_IDLE;
    assign accept       = req_valid && !req_stall;
    assign out_free     = !out_valid_reg || !rsp_stall;

    assign ctx_rd_en   = accept && in_range_now;
    assign ctx_rd_addr = client_ext[CIDX_W-1:0];

    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_eff = LIMIT_W'(1);
        end
        else if (limit_reg > LIMIT_W'(LIMIT_CAP))
        begin
            lim_eff = LIMIT_W'(LIMIT_CAP);
        end
        else
        begin
            lim_eff = limit_reg;
        end
    end

    assign full      = ctx_rd_count >= lim_eff;
    assign tail_slot = wrap_add(ctx_rd_head, ctx_rd_count);
    assign cnt_inc   = ctx_rd_count + COUNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        drop_slot_next  = drop_slot_reg;
        drop_head_next  = drop_head_reg;
        drop_cnt_next   = drop_cnt_reg;
        drain_head_next = drain_head_reg;
        drain_cnt_next  = drain_cnt_reg;
        drain_idx_next  = drain_idx_reg;
        dv_next         = dv_reg;
        drain_issue     = 1'b0;
        out_load        = 1'b0;
        out_item        = make_rsp(STAT_OK, '0, '0, 1'b1);
        ctx_wr_en       = 1'b0;
        ctx_wr_addr     = client_reg;
        ctx_wr_head     = '0;
        ctx_wr_count    = '0;
        msg_rd_en       = 1'b0;
        msg_rd_addr     = {client_reg, ctx_rd_head};
        msg_wr_en       = 1'b0;
        msg_wr_addr     = {client_reg, tail_slot};
        msg_wr_data     = req_reg.message_handle;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (!in_range_reg)
                    begin
                        unique case (req_reg.cmd)
                            CMD_ENQ, CMD_ENQ_DROP:
                            begin
                                out_load = 1'b1;
                                out_item = make_rsp(STAT_FULL, '0, '0, 1'b1);
                            end
                            CMD_DRAIN:
                            begin
                                out_load = 1'b1;
                                out_item = make_rsp(STAT_EMPTY, '0, '0, 1'b1);
                            end
                            CMD_SIZE, CMD_PURGE:
                            begin
                                out_load = 1'b1;
                                out_item = make_rsp(STAT_OK, '0, '0, 1'b1);
                            end
                            default:
                            begin
                                out_load = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (req_reg.cmd)
                            CMD_ENQ, CMD_ENQ_DROP:
                            begin
                                if (full && req_reg.cmd == CMD_ENQ)
                                begin
                                    out_load = 1'b1;
                                    out_item = make_rsp(STAT_FULL, '0, ctx_rd_count, 1'b1);
                                end
                                else if (full)
                                begin
                                    // evict: fetch the oldest entry first
                                    msg_rd_en      = 1'b1;
                                    drop_slot_next = tail_slot;
                                    drop_head_next = wrap_add(ctx_rd_head, COUNT_W'(1));
                                    drop_cnt_next  = ctx_rd_count;
                                    state_next     = S_DROP;
                                end
                                else
                                begin
                                    msg_wr_en    = 1'b1;
                                    ctx_wr_en    = 1'b1;
                                    ctx_wr_head  = ctx_rd_head;
                                    ctx_wr_count = cnt_inc;
                                    out_load     = 1'b1;
                                    out_item     = make_rsp(STAT_OK, '0, cnt_inc, 1'b1);
                                end
                            end
                            CMD_DRAIN:
                            begin
                                ctx_wr_en = 1'b1;
                                if (ctx_rd_count == '0)
                                begin
                                    out_load = 1'b1;
                                    out_item = make_rsp(STAT_EMPTY, '0, '0, 1'b1);
                                end
                                else
                                begin
                                    drain_head_next = ctx_rd_head;
                                    drain_cnt_next  = ctx_rd_count;
                                    drain_idx_next  = '0;
                                    dv_next         = 1'b0;
                                    state_next      = S_DRAIN;
                                end
                            end
                            CMD_SIZE:
                            begin
                                out_load = 1'b1;
                                out_item = make_rsp(STAT_OK, '0, ctx_rd_count, 1'b1);
                            end
                            CMD_PURGE:
                            begin
                                ctx_wr_en = 1'b1;
                                out_load  = 1'b1;
                                out_item  = make_rsp(STAT_OK, '0, '0, 1'b1);
                            end
                            default:
                            begin
                                out_load = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_DROP:
            begin
                if (out_free)
                begin
                    msg_wr_en    = 1'b1;
                    msg_wr_addr  = {client_reg, drop_slot_reg};
                    ctx_wr_en    = 1'b1;
                    ctx_wr_head  = drop_head_reg;
                    ctx_wr_count = drop_cnt_reg;
                    out_load     = 1'b1;
                    out_item     = make_rsp(STAT_DROPPED, msg_rd_data, drop_cnt_reg, 1'b1);
                    state_next   = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                out_load    = dv_reg && out_free;
                out_item    = make_rsp(STAT_DRAINED, msg_rd_data, '0,
                                       drain_idx_reg == drain_cnt_reg);
                drain_issue = (drain_idx_reg != drain_cnt_reg) && (!dv_reg || out_load);
                msg_rd_en   = drain_issue;
                msg_rd_addr = {client_reg, wrap_add(drain_head_reg, drain_idx_reg)};
                if (drain_issue)
                begin
                    drain_idx_next = drain_idx_reg + COUNT_W'(1);
                    dv_next        = 1'b1;
                end
                else if (out_load)
                begin
                    dv_next = 1'b0;
                end
                if (out_load && drain_idx_reg == drain_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            dv_reg        <= 1'b0;
            drain_idx_reg <= '0;
            drain_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dv_reg        <= dv_next;
            drain_idx_reg <= drain_idx_next;
            drain_cnt_reg <= drain_cnt_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req_data;
            in_range_reg <= in_range_now;
            client_reg   <= client_ext[CIDX_W-1:0];
        end
        if (out_load)
        begin
            out_data_reg <= out_item;
        end
        drop_slot_reg  <= drop_slot_next;
        drop_head_reg  <= drop_head_next;
        drop_cnt_reg   <= drop_cnt_next;
        drain_head_reg <= drain_head_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    `BCQ_ASSERT_IMP(a_dv_only_in_drain, dv_reg, state_reg == S_DRAIN)
    `BCQ_ASSERT_IMP(a_drain_idx_bound, state_reg == S_DRAIN, drain_idx_reg <= drain_cnt_reg)
    `BCQ_ASSERT_NXT(a_drain_exit, state_reg == S_DRAIN && out_load && drain_idx_reg == drain_cnt_reg, state_reg == S_IDLE)
    `BCQ_ASSERT_IMP(a_ctx_count_bound, ctx_wr_en, ctx_wr_count <= COUNT_W'(LIMIT_CAP))
    `BCQ_ASSERT_IMP(a_msg_port_exclusive, msg_wr_en, !msg_rd_en)

endmodule

// ===== rtl/per_client_bounded_queue_manager.sv =====
// ----------------------------------------------------------------------------
// per_client_bounded_queue_manager
// enqueue, size and purge: context read register, then result register; no new request
// is taken until the lookup state is left (at most one context read-modify-write)
// enqueue with drop at the limit: lookup, then drop state, one extra message memory read
// drain of n entries: one entry per cycle from the message read port while rsp_stall is low
// reset: depth limit 16, all queues empty at once, message memory not cleared
// ----------------------------------------------------------------------------
module per_client_bounded_queue_manager #(
    parameter int NUM_CLIENTS = bcq_pkg::NUM_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = bcq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bcq_pkg::req_item_t          req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output bcq_pkg::rsp_item_t          rsp_data,
    input  logic                        cfg_we,
    input  logic [bcq_pkg::LIMIT_W-1:0] cfg_wdata
);
    import bcq_pkg::*;

    localparam int CIDX_W = idx_w(NUM_CLIENTS);
    localparam int PTR_W  = idx_w(QUEUE_DEPTH);

    logic                      ctx_rd_en;
    logic [CIDX_W-1:0]         ctx_rd_addr;
    logic [PTR_W-1:0]          ctx_rd_head;
    logic [COUNT_W-1:0]        ctx_rd_count;
    logic                      ctx_wr_en;
    logic [CIDX_W-1:0]         ctx_wr_addr;
    logic [PTR_W-1:0]          ctx_wr_head;
    logic [COUNT_W-1:0]        ctx_wr_count;
    logic                      msg_rd_en;
    logic [CIDX_W+PTR_W-1:0]   msg_rd_addr;
    logic [DATA_W-1:0]         msg_rd_data;
    logic                      msg_wr_en;
    logic [CIDX_W+PTR_W-1:0]   msg_wr_addr;
    logic [DATA_W-1:0]         msg_wr_data;

    bcq_ctrl #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_data     (req_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_data     (rsp_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ctx_rd_en    (ctx_rd_en),
        .ctx_rd_addr  (ctx_rd_addr),
        .ctx_rd_head  (ctx_rd_head),
        .ctx_rd_count (ctx_rd_count),
        .ctx_wr_en    (ctx_wr_en),
        .ctx_wr_addr  (ctx_wr_addr),
        .ctx_wr_head  (ctx_wr_head),
        .ctx_wr_count (ctx_wr_count),
        .msg_rd_en    (msg_rd_en),
        .msg_rd_addr  (msg_rd_addr),
        .msg_rd_data  (msg_rd_data),
        .msg_wr_en    (msg_wr_en),
        .msg_wr_addr  (msg_wr_addr),
        .msg_wr_data  (msg_wr_data)
    );

    bcq_ctx_mem #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctx_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (ctx_rd_en),
        .rd_addr  (ctx_rd_addr),
        .rd_head  (ctx_rd_head),
        .rd_count (ctx_rd_count),
        .wr_en    (ctx_wr_en),
        .wr_addr  (ctx_wr_addr),
        .wr_head  (ctx_wr_head),
        .wr_count (ctx_wr_count)
    );

    bcq_msg_mem #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_msg_mem (
        .clk     (clk),
        .rd_en   (msg_rd_en),
        .rd_addr (msg_rd_addr),
        .rd_data (msg_rd_data),
        .wr_en   (msg_wr_en),
        .wr_addr (msg_wr_addr),
        .wr_data (msg_wr_data)
    );

endmodule
